### rtl/lfsb_pkg.sv
// Package for the leftmost-fill stack bank: sizes, field widths, operation and
// status codes, and the request word of the shared compare unit.
// No dependencies.
`timescale 1ns / 1ps
package lfsb_pkg;

  localparam int NUM_STACKS   = 16;
  localparam int MAX_CAPACITY = 16;
  localparam int DATA_WIDTH   = 32;

  // Fixed field widths of the stream words
  localparam int FUNC_W  = 2;
  localparam int VALUE_W = 32;
  localparam int SEL_W   = 4;
  localparam int STAT_W  = 2;
  localparam int CFG_W   = 5;

  // Derived sizes
  localparam int SIDX_W    = $clog2(NUM_STACKS);
  localparam int CNT_W     = $clog2(MAX_CAPACITY + 1);
  localparam int SLOT_W    = $clog2(MAX_CAPACITY);
  localparam int ADDR_W    = SIDX_W + SLOT_W;
  localparam int RAM_DEPTH = NUM_STACKS * MAX_CAPACITY;

  // Stream word widths, padded to whole bytes
  localparam int IN_BITS  = FUNC_W + VALUE_W + SEL_W;
  localparam int OUT_BITS = VALUE_W + STAT_W + SEL_W;
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [CFG_W-1:0] CAP_RESET = CFG_W'(16);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUSH   = 2'd0,
    FUNC_POP    = 2'd1,
    FUNC_POP_AT = 2'd2
  } func_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Request to the shared compare unit
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [CNT_W-1:0] cap;
    logic             want_room;
  } cmp_req_t;

endpackage

### rtl/leftmost_fill_stack_bank_unit.sv
// Leftmost-fill stack bank: push to leftmost stack with room, pop from the
// rightmost non-empty stack, or pop at a named stack.
// Steps: an unused code or out-of-range pop-at goes straight to S_OUT; else S_SCAN
// tests one fill count a cycle via the shared compare, S_READ reads the RAM for a
// pop, and S_OUT loads the output register; new words are taken only in S_IDLE.
// Reset (synchronous, rst_n low): fill counts cleared, capacity 16; plates undefined.
`timescale 1ns / 1ps
module leftmost_fill_stack_bank_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  // Input stream
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // tdata: func[1:0], plate_value[33:2], stack_select[37:34], zero pad
  input  logic [lfsb_pkg::IN_W-1:0]     in_tdata,
  // Result stream
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // tdata: popped_value[31:0], status[33:32], served_stack[37:34], zero pad
  output logic [lfsb_pkg::OUT_W-1:0]    out_tdata,
  // Configuration
  input  logic                          cfg_we,
  input  logic [lfsb_pkg::CFG_W-1:0]    cfg_wdata
);

  localparam int FW = lfsb_pkg::FUNC_W;
  localparam int VW = lfsb_pkg::VALUE_W;
  localparam int SW = lfsb_pkg::SEL_W;
  localparam int TW = lfsb_pkg::STAT_W;
  localparam int CW = lfsb_pkg::CNT_W;
  localparam int IW = lfsb_pkg::SIDX_W;
  localparam int LW = lfsb_pkg::SLOT_W;
  localparam int DW = lfsb_pkg::DATA_WIDTH;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_READ,
    S_OUT
  } state_t;

  state_t state_r;

  logic [lfsb_pkg::CFG_W-1:0] cap_r;
  logic [CW-1:0]              fill_r [lfsb_pkg::NUM_STACKS];
  logic [IW-1:0]              idx_r;
  logic                       is_push_r;
  logic                       is_pop_at_r;
  logic [DW-1:0]              val_r;

  logic [VW-1:0]              res_popped_r;
  logic [TW-1:0]              res_status_r;
  logic [SW-1:0]              res_served_r;

  logic                       out_valid_r;
  logic [VW-1:0]              out_popped_r;
  logic [TW-1:0]              out_status_r;
  logic [SW-1:0]              out_served_r;

  // Input word fields
  logic [FW-1:0] in_func;
  logic [VW-1:0] in_value;
  logic [SW-1:0] in_sel;

  assign in_func  = in_tdata[FW-1:0];
  assign in_value = in_tdata[FW+VW-1:FW];
  assign in_sel   = in_tdata[FW+VW+SW-1:FW+VW];

  // Clamp the capacity register into range
  logic [CW-1:0] cap_eff;
  always_comb begin
    if (cap_r == '0) begin
      cap_eff = CW'(1);
    end else if (cap_r > lfsb_pkg::CFG_W'(lfsb_pkg::MAX_CAPACITY)) begin
      cap_eff = CW'(lfsb_pkg::MAX_CAPACITY);
    end else begin
      cap_eff = CW'(cap_r);
    end
  end

  // Shared compare on the fill count under the scan index
  logic [CW-1:0]      cnt;
  logic [CW-1:0]      cnt_dec;
  lfsb_pkg::cmp_req_t cmp_req;
  logic               hit;
  logic               scan_end;

  assign cnt     = fill_r[idx_r];
  assign cnt_dec = cnt - 1'b1;

  always_comb begin
    cmp_req.count     = cnt;
    cmp_req.cap       = cap_eff;
    cmp_req.want_room = is_push_r;
  end

  lfsb_cmp u_cmp (
    .req (cmp_req),
    .hit (hit)
  );

  assign scan_end = is_pop_at_r ||
                    (is_push_r && (idx_r == IW'(lfsb_pkg::NUM_STACKS - 1))) ||
                    (!is_push_r && (idx_r == '0));

  // Plate memory, one row of MAX_CAPACITY slots per stack
  logic                  ram_we;
  logic                  ram_re;
  logic [IW+LW-1:0]      ram_waddr;
  logic [IW+LW-1:0]      ram_raddr;
  logic [DW-1:0]         ram_rdata;

  assign ram_we    = (state_r == S_SCAN) && hit && is_push_r;
  assign ram_re    = (state_r == S_SCAN) && hit && !is_push_r;
  assign ram_waddr = {idx_r, cnt[LW-1:0]};
  assign ram_raddr = {idx_r, cnt_dec[LW-1:0]};

  lfsb_ram #(
    .WIDTH (DW),
    .DEPTH (lfsb_pkg::RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (val_r),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Load the output register when a result is ready and the register is free
  logic out_load;
  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_tready);

  // Sequencer, fill counts and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cap_r       <= lfsb_pkg::CAP_RESET;
      for (int i = 0; i < lfsb_pkg::NUM_STACKS; i++) begin
        fill_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            val_r        <= DW'(in_value);
            res_popped_r <= '0;
            res_served_r <= '0;
            is_push_r    <= (in_func == lfsb_pkg::FUNC_PUSH);
            is_pop_at_r  <= (in_func == lfsb_pkg::FUNC_POP_AT);
            unique case (in_func)
              lfsb_pkg::FUNC_PUSH: begin
                res_status_r <= lfsb_pkg::ST_OK;
                idx_r        <= '0;
                state_r      <= S_SCAN;
              end
              lfsb_pkg::FUNC_POP: begin
                res_status_r <= lfsb_pkg::ST_OK;
                idx_r        <= IW'(lfsb_pkg::NUM_STACKS - 1);
                state_r      <= S_SCAN;
              end
              lfsb_pkg::FUNC_POP_AT: begin
                if (32'(in_sel) < lfsb_pkg::NUM_STACKS) begin
                  res_status_r <= lfsb_pkg::ST_OK;
                  idx_r        <= IW'(in_sel);
                  state_r      <= S_SCAN;
                end else begin
                  res_status_r <= lfsb_pkg::ST_EMPTY;
                  state_r      <= S_OUT;
                end
              end
              default: begin
                // Unused operation: all-zero result
                res_status_r <= lfsb_pkg::ST_OK;
                state_r      <= S_OUT;
              end
            endcase
          end
        end

        S_SCAN: begin
          if (hit) begin
            res_served_r <= SW'(idx_r);
            if (is_push_r) begin
              fill_r[idx_r] <= CW'(cnt + 1'b1);
              state_r       <= S_OUT;
            end else begin
              fill_r[idx_r] <= cnt_dec;
              state_r       <= S_READ;
            end
          end else if (scan_end) begin
            res_status_r <= is_push_r ? lfsb_pkg::ST_FULL : lfsb_pkg::ST_EMPTY;
            state_r      <= S_OUT;
          end else if (is_push_r) begin
            idx_r <= idx_r + 1'b1;
          end else begin
            idx_r <= idx_r - 1'b1;
          end
        end

        S_READ: begin
          res_popped_r <= VW'(ram_rdata);
          state_r      <= S_OUT;
        end

        S_OUT: begin
          // Hold until the output register is free
          if (out_load) begin
            out_popped_r <= res_popped_r;
            out_status_r <= res_status_r;
            out_served_r <= res_served_r;
            state_r      <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(lfsb_pkg::OUT_W - lfsb_pkg::OUT_BITS)'(0),
                       out_served_r, out_status_r, out_popped_r};

endmodule

### rtl/lfsb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module lfsb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/lfsb_cmp.sv
// Shared fill-count compare unit: room-left test for push, non-empty test
// for pop. Depends on lfsb_pkg.
`timescale 1ns / 1ps
module lfsb_cmp (
  input  lfsb_pkg::cmp_req_t req,
  output logic               hit
);

  // Room below capacity, or at least one plate present
  always_comb begin
    if (req.want_room) begin
      hit = (req.count < req.cap);
    end else begin
      hit = (req.count != '0);
    end
  end

endmodule
